// ===== src/bep_pkg.sv =====
// Shared types and constants for the band envelope / peak hold block.
// No dependencies; every other file in src imports this package.
`default_nettype none

package bep_pkg;

    localparam int BAND_W     = 5;
    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 2 * (LEVEL_W + 1);

    localparam logic [LEVEL_W-1:0] ATTACK_RST  = 16'd65535;
    localparam logic [LEVEL_W-1:0] RELEASE_RST = 16'd8192;
    localparam logic [LEVEL_W-1:0] DECAY_RST   = 16'd655;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_DECAY   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_coeff;
        logic [LEVEL_W-1:0] release_coeff;
        logic [LEVEL_W-1:0] peak_decay_step;
    } t_cfg;

    // One store entry: held peak and smoothed level of a band.
    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] level;
    } t_env;

endpackage

`default_nettype wire

// ===== src/bep_in_if.sv =====
// Input channel: band index and target level with valid/ready.
// Depends on bep_pkg for field widths.
`default_nettype none

interface bep_in_if;
    import bep_pkg::*;

    logic               valid;
    logic               ready;
    logic [BAND_W-1:0]  band_index;
    logic [LEVEL_W-1:0] target_level;

    modport source (output valid, output band_index, output target_level, input ready);
    modport sink   (input valid, input band_index, input target_level, output ready);
endinterface

`default_nettype wire

// ===== src/bep_out_if.sv =====
// Result channel: band, smoothed level and held peak with valid/ready.
// Depends on bep_pkg for field widths.
`default_nettype none

interface bep_out_if;
    import bep_pkg::*;

    logic               valid;
    logic               ready;
    logic [BAND_W-1:0]  band_out;
    logic [LEVEL_W-1:0] smoothed_level;
    logic [LEVEL_W-1:0] held_peak;

    modport source (output valid, output band_out, output smoothed_level, output held_peak,
                    input ready);
    modport sink   (input valid, input band_out, input smoothed_level, input held_peak,
                    output ready);
endinterface

`default_nettype wire

// ===== src/bep_cfg_regs.sv =====
// Configuration registers: attack, release and peak decay step.
// Depends on bep_pkg.
`default_nettype none

module bep_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bep_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bep_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bep_pkg::t_cfg                    o_cfg
);
    import bep_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff    <= ATTACK_RST;
            r_cfg.release_coeff   <= RELEASE_RST;
            r_cfg.peak_decay_step <= DECAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK:  r_cfg.attack_coeff    <= i_cfg_data;
                CFG_RELEASE: r_cfg.release_coeff   <= i_cfg_data;
                CFG_DECAY:   r_cfg.peak_decay_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/bep_env_mem.sv =====
// Per-band state memory {peak, level}: one write port, one registered read port,
// and a clearing sweep after reset. Depends on bep_pkg.
`default_nettype none

module bep_env_mem #(
    parameter int BANDS = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output bep_pkg::t_env    o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  bep_pkg::t_env    i_wr_data,
    output logic             o_clearing
);
    import bep_pkg::*;

    t_env          r_mem [BANDS];
    t_env          r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(BANDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-during-write to the same entry returns the old data; caller forwards.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== src/bep_update.sv =====
// Envelope update datapath: multiply stage into a product register, then step,
// clamp and peak merge. Depends on bep_pkg.
`default_nettype none

module bep_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bep_pkg::t_cfg                 i_cfg,
    input  logic                          i_load,
    input  logic [bep_pkg::BAND_W-1:0]    i_band,
    input  logic [bep_pkg::LEVEL_W-1:0]   i_target,
    input  bep_pkg::t_env                 i_env,
    input  logic                          i_advance,
    output logic                          o_valid,
    output logic [bep_pkg::BAND_W-1:0]    o_band,
    output bep_pkg::t_env                 o_env
);
    import bep_pkg::*;

    logic                      w_rise;
    logic [LEVEL_W-1:0]        w_coeff;
    logic signed [LEVEL_W:0]   w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0]        w_decayed;

    logic                      r_valid;
    logic [BAND_W-1:0]         r_band;
    logic [LEVEL_W-1:0]        r_level;
    logic [LEVEL_W-1:0]        r_decayed;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [LEVEL_W+1:0] w_step;
    logic signed [LEVEL_W+2:0] w_sum;
    logic [LEVEL_W-1:0]        w_next;
    logic [LEVEL_W-1:0]        w_peak;

    // multiply stage
    always_comb begin
        w_rise    = i_target > i_env.level;
        w_coeff   = w_rise ? i_cfg.attack_coeff : i_cfg.release_coeff;
        w_diff    = $signed({1'b0, i_target}) - $signed({1'b0, i_env.level});
        w_prod    = $signed({1'b0, w_coeff}) * w_diff;
        w_decayed = (i_env.peak > i_cfg.peak_decay_step) ?
                    i_env.peak - i_cfg.peak_decay_step : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_band    <= i_band;
            r_level   <= i_env.level;
            r_decayed <= w_decayed;
            r_prod    <= w_prod;
        end
    end

    // upper bits of the product are the floor of p / 2^16
    always_comb begin
        w_step = r_prod[PROD_W-1:LEVEL_W];
        w_sum  = $signed({3'b000, r_level}) + $signed({w_step[LEVEL_W+1], w_step});
        if (w_sum[LEVEL_W+2]) begin
            w_next = '0;
        end else if (w_sum[LEVEL_W+1:LEVEL_W] != 2'b00) begin
            w_next = LEVEL_MAX;
        end else begin
            w_next = w_sum[LEVEL_W-1:0];
        end
        w_peak = (w_next > r_decayed) ? w_next : r_decayed;
    end

    assign o_valid     = r_valid;
    assign o_band      = r_band;
    assign o_env.level = w_next;
    assign o_env.peak  = w_peak;

endmodule

`default_nettype wire

// ===== src/band_envelope_peak_hold.sv =====
// Per-band attack/release envelope follower with decaying peak hold.
// A result passes the read stage, the product register of the update and the output register.
// Throughput: one item per cycle while the output is not stalled; an item for the same band as
// the item just before it waits for that item's write-back (read-modify-write loop of the memory).
// Reset: synchronous; after reset the state memory is cleared entry by entry, during
// which no item is taken. Configuration writes are taken at any time.
`default_nettype none

module band_envelope_peak_hold #(
    parameter int BANDS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bep_in_if.sink                          i_in,
    bep_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [bep_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bep_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bep_pkg::*;

    localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

    t_cfg               w_cfg;
    logic               w_clearing;
    t_env               w_rd_data;

    logic               r_s1_valid;
    logic [BAND_W-1:0]  r_s1_band;
    logic [LEVEL_W-1:0] r_s1_target;
    logic               r_s1_fwd_valid;
    t_env               r_s1_fwd;
    t_env               w_s1_env;

    logic               w_p_valid;
    logic [BAND_W-1:0]  w_p_band;
    t_env               w_p_env;

    logic               r_o_valid;
    logic [BAND_W-1:0]  r_o_band;
    t_env               r_o_env;

    logic               w_o_free;
    logic               w_p_go;
    logic               w_p_free;
    logic               w_hazard;
    logic               w_s1_go;
    logic               w_s1_free;
    logic               w_in_ready;
    logic               w_in_ok;
    logic               w_load_s1;

    bep_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // pipeline control
    always_comb begin
        w_o_free   = !r_o_valid || o_out.ready;
        w_p_go     = w_p_valid && w_o_free;
        w_p_free   = !w_p_valid || w_o_free;
        w_hazard   = w_p_valid && (w_p_band == r_s1_band);
        w_s1_go    = r_s1_valid && w_p_free && !w_hazard;
        w_s1_free  = !r_s1_valid || w_s1_go;
        w_in_ready = w_s1_free && !w_clearing;
        w_in_ok    = 32'(i_in.band_index) < BANDS;
        w_load_s1  = i_in.valid && w_in_ready && w_in_ok;
    end

    bep_env_mem #(
        .BANDS (BANDS),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_load_s1),
        .i_rd_addr  (AW'(i_in.band_index)),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_p_go),
        .i_wr_addr  (AW'(w_p_band)),
        .i_wr_data  (w_p_env),
        .o_clearing (w_clearing)
    );

    // read stage; snoops write-backs to its band that land after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_fwd_valid <= 1'b0;
        end else begin
            if (w_load_s1) begin
                r_s1_valid     <= 1'b1;
                r_s1_fwd_valid <= w_p_go && (w_p_band == i_in.band_index);
            end else begin
                if (w_s1_go) begin
                    r_s1_valid <= 1'b0;
                end
                if (r_s1_valid && w_p_go && (w_p_band == r_s1_band)) begin
                    r_s1_fwd_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_s1) begin
            r_s1_band   <= i_in.band_index;
            r_s1_target <= i_in.target_level;
            r_s1_fwd    <= w_p_env;
        end else if (r_s1_valid && w_p_go && (w_p_band == r_s1_band)) begin
            r_s1_fwd    <= w_p_env;
        end
    end

    assign w_s1_env = r_s1_fwd_valid ? r_s1_fwd : w_rd_data;

    bep_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_load    (w_s1_go),
        .i_band    (r_s1_band),
        .i_target  (r_s1_target),
        .i_env     (w_s1_env),
        .i_advance (w_p_go),
        .o_valid   (w_p_valid),
        .o_band    (w_p_band),
        .o_env     (w_p_env)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_go) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_go) begin
            r_o_band <= w_p_band;
            r_o_env  <= w_p_env;
        end
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_o_valid;
    assign o_out.band_out       = r_o_band;
    assign o_out.smoothed_level = r_o_env.level;
    assign o_out.held_peak      = r_o_env.peak;

`ifndef SYNTHESIS
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !r_s1_valid && !w_p_valid && !r_o_valid)
        else $error("items in flight during memory clear");

    a_fwd_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_go && w_p_go && (w_p_band == r_s1_band) |=> r_s1_fwd_valid)
        else $error("write-back to waiting band not forwarded");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(w_p_go))
        else $error("result appeared without a write-back");

    a_peak_ge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_env.peak >= r_o_env.level)
        else $error("held peak below smoothed level");
`endif

endmodule

`default_nettype wire

// ===== test/band_envelope_peak_hold_tb.sv =====
// Testbench for band_envelope_peak_hold: streams band target levels, predicts each band's
// smoothed level and held peak, and checks every result against the oldest expectation.
// Depends on bep_pkg, bep_in_if, bep_out_if and band_envelope_peak_hold from src.
`timescale 1ns / 1ps

module band_envelope_peak_hold_tb;
    import bep_pkg::*;

    localparam int NUM_BANDS     = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
    } t_band_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bep_in_if  band_in ();
    bep_out_if band_res ();

    band_envelope_peak_hold #(
        .BANDS(NUM_BANDS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (band_in),
        .o_out      (band_res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state, mirrors the block's per-band stores and registers
    t_cfg               coeffs = '{ATTACK_RST, RELEASE_RST, DECAY_RST};
    logic [LEVEL_W-1:0] level_mem [NUM_BANDS] = '{default: '0};
    logic [LEVEL_W-1:0] peak_mem  [NUM_BANDS] = '{default: '0};
    t_band_result       pending_envelopes [$];
    t_band_result       accepted_env;
    t_band_result       expected_env;

    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 src_idle_pct   = 0;
    int                 snk_stall_pct  = 0;
    logic [BAND_W-1:0]  last_band      = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_band_result envelope_update(input logic [BAND_W-1:0] band,
                                                     input logic [LEVEL_W-1:0] tgt,
                                                     input logic [LEVEL_W-1:0] lvl,
                                                     input logic [LEVEL_W-1:0] pk,
                                                     input t_cfg c);
        logic [LEVEL_W-1:0]       coeff;
        logic signed [LEVEL_W:0]  diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        logic [LEVEL_W-1:0]       next_lvl;
        logic [LEVEL_W-1:0]       next_pk;
        t_band_result             r;
        coeff = (tgt > lvl) ? c.attack_coeff : c.release_coeff;
        diff  = $signed({1'b0, tgt}) - $signed({1'b0, lvl});
        prod  = $signed({1'b0, coeff}) * diff;
        // arithmetic shift floors, so a rising level can stop one code short of its target
        sum   = $signed({{(PROD_W - LEVEL_W){1'b0}}, lvl}) + (prod >>> LEVEL_W);
        if (sum < 0) begin
            next_lvl = '0;
        end else if (sum > $signed({{(PROD_W - LEVEL_W){1'b0}}, LEVEL_MAX})) begin
            next_lvl = LEVEL_MAX;
        end else begin
            next_lvl = sum[LEVEL_W-1:0];
        end
        next_pk = (pk > c.peak_decay_step) ? pk - c.peak_decay_step : '0;
        if (next_lvl > next_pk) begin
            next_pk = next_lvl;
        end
        r.band  = band;
        r.level = next_lvl;
        r.peak  = next_pk;
        return r;
    endfunction

    // each input transfer updates the predicted stores and queues one result
    always @(posedge i_clk) begin
        if (i_rst_n && band_in.valid && band_in.ready) begin
            accepted_env = envelope_update(band_in.band_index, band_in.target_level,
                                           level_mem[band_in.band_index],
                                           peak_mem[band_in.band_index], coeffs);
            level_mem[band_in.band_index] = accepted_env.level;
            peak_mem[band_in.band_index]  = accepted_env.peak;
            pending_envelopes.push_back(accepted_env);
        end
    end

    task automatic flag_mismatch(input string what, input logic [LEVEL_W-1:0] exp_val,
                                 input logic [LEVEL_W-1:0] got_val);
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_val,
                 got_val);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && band_res.valid && band_res.ready) begin
            if (pending_envelopes.size() == 0) begin
                flag_mismatch("result with nothing pending", '0,
                              LEVEL_W'(band_res.band_out));
            end else begin
                expected_env = pending_envelopes.pop_front();
                if (band_res.band_out !== expected_env.band)
                    flag_mismatch("band_out", LEVEL_W'(expected_env.band),
                                  LEVEL_W'(band_res.band_out));
                if (band_res.smoothed_level !== expected_env.level)
                    flag_mismatch("smoothed_level", expected_env.level,
                                  band_res.smoothed_level);
                if (band_res.held_peak !== expected_env.peak)
                    flag_mismatch("held_peak", expected_env.peak, band_res.held_peak);
            end
        end
    end

    // result side backpressure
    initial begin
        band_res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            band_res.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_band(input logic [BAND_W-1:0] band, input logic [LEVEL_W-1:0] tgt);
        while ($urandom_range(99) < src_idle_pct) begin
            band_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        band_in.valid        <= 1'b1;
        band_in.band_index   <= band;
        band_in.target_level <= tgt;
        @(posedge i_clk);
        while (!band_in.ready) @(posedge i_clk);
        last_band = band;
    endtask

    // stop sending, let every pending result come back, then let the pipe settle
    task automatic wait_until_drained();
        band_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_envelopes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // the strobe is dropped and the task waits again after each write, so back-to-back writes stay on separate edges
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_ATTACK:  coeffs.attack_coeff    = data;
            CFG_RELEASE: coeffs.release_coeff   = data;
            CFG_DECAY:   coeffs.peak_decay_step = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_coeffs(input logic [LEVEL_W-1:0] attack, input logic [LEVEL_W-1:0] rel,
                              input logic [LEVEL_W-1:0] decay);
        wait_until_drained();
        write_reg(CFG_ATTACK, attack);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_DECAY, decay);
    endtask

    function automatic logic [LEVEL_W-1:0] pick_coeff();
        case ($urandom_range(3))
            0:       return '0;
            1:       return LEVEL_MAX;
            default: return LEVEL_W'($urandom_range(65535));
        endcase
    endfunction

    // bands cluster on a few hot indexes and repeats so the same-band hazard is hit often
    task automatic run_random_chunks(input int chunks, input int per_chunk);
        int                 r;
        int                 near;
        int                 hot_base;
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] tgt;
        for (int c = 0; c < chunks; c++) begin
            set_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
            hot_base = $urandom_range(NUM_BANDS - 4);
            for (int i = 0; i < per_chunk; i++) begin
                r = $urandom_range(99);
                if (r < 25)
                    band = last_band;
                else if (r < 60)
                    band = BAND_W'(hot_base + int'($urandom_range(3)));
                else
                    band = BAND_W'($urandom_range(NUM_BANDS - 1));
                r = $urandom_range(99);
                if (r < 12) begin
                    tgt = '0;
                end else if (r < 24) begin
                    tgt = LEVEL_MAX;
                end else if (r < 50) begin
                    near = int'(level_mem[band]) + int'($urandom_range(64)) - 32;
                    if (near < 0) near = 0;
                    if (near > 65535) near = 65535;
                    tgt = LEVEL_W'(near);
                end else begin
                    tgt = LEVEL_W'($urandom_range(65535));
                end
                send_band(band, tgt);
            end
        end
    endtask

    task automatic test_default_settings();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_band(5'd0, LEVEL_MAX);
        send_band(5'd0, LEVEL_MAX);
        send_band(5'd0, 16'd0);
        send_band(5'd31, LEVEL_MAX);
        send_band(5'd31, 16'd0);
        send_band(5'd17, 16'h5555);
        send_band(5'd10, 16'hAAAA);
    endtask

    // zero coefficients freeze the level; a decay above the peak floors it at zero
    task automatic test_zero_coeffs_big_decay();
        set_coeffs('0, '0, LEVEL_MAX);
        send_band(5'd3, LEVEL_MAX);
        send_band(5'd0, 16'd0);
        send_band(5'd31, LEVEL_MAX);
    endtask

    // full coefficients, no decay; the write to the unmapped index must change nothing
    task automatic test_full_coeffs_unmapped_write();
        set_coeffs(LEVEL_MAX, LEVEL_MAX, '0);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_band(5'd0, 16'd0);
        send_band(5'd0, LEVEL_MAX);
        send_band(5'd5, 16'd1);
        send_band(5'd5, 16'd0);
    endtask

    task automatic test_slow_receiver();
        src_idle_pct  = 10;
        snk_stall_pct = 55;
        run_random_chunks(5, 100);
    endtask

    task automatic test_slow_sender();
        src_idle_pct  = 55;
        snk_stall_pct = 10;
        run_random_chunks(5, 100);
    endtask

    task automatic test_no_idling();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random_chunks(5, 100);
    endtask

    // sender holds off mid-stream until every result is back, then resumes
    task automatic test_pause_until_empty();
        src_idle_pct  = 10;
        snk_stall_pct = 30;
        for (int i = 0; i < 30; i++) begin
            if (i == 15) wait_until_drained();
            send_band(BAND_W'($urandom_range(NUM_BANDS - 1)), LEVEL_W'($urandom_range(65535)));
        end
    endtask

    initial begin
        band_in.valid        <= 1'b0;
        band_in.band_index   <= '0;
        band_in.target_level <= '0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        i_rst_n              <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_settings();
        test_zero_coeffs_big_decay();
        test_full_coeffs_unmapped_write();
        test_slow_receiver();
        test_slow_sender();
        test_no_idling();
        test_pause_until_empty();
        wait_until_drained();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bep_pkg.sv
src/bep_in_if.sv
src/bep_out_if.sv
src/bep_cfg_regs.sv
src/bep_env_mem.sv
src/bep_update.sv
src/band_envelope_peak_hold.sv
test/band_envelope_peak_hold_tb.sv
